// File: src/lzs_pkg.sv
// Shared types, phase codes, substream codes and the block-start helper for the splitter.
`timescale 1ns / 1ps
package lzs_pkg;

    localparam int HEADER_BYTES = 6;

    localparam int BLK_CNT_W = 24;
    localparam int LIT_CNT_W = 9;
    localparam int HDR_IDX_W = 3;
    localparam int PHASE_W   = 3;
    localparam int SEL_W     = 3;

    // Parse phases
    localparam logic [PHASE_W-1:0] PH_HEADER = 3'd0;
    localparam logic [PHASE_W-1:0] PH_SIZE   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXTRA  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LITS   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_OFFLO  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_OFFHI  = 3'd5;
    localparam logic [PHASE_W-1:0] PH_DONE   = 3'd6;

    // Substream codes
    localparam logic [SEL_W-1:0] SEL_SIZE  = 3'd0;
    localparam logic [SEL_W-1:0] SEL_OFFHI = 3'd1;
    localparam logic [SEL_W-1:0] SEL_OFFLO = 3'd2;
    localparam logic [SEL_W-1:0] SEL_LIT   = 3'd3;
    localparam logic [SEL_W-1:0] SEL_XLIT  = 3'd4;
    localparam logic [SEL_W-1:0] SEL_XREP  = 3'd5;

    localparam logic [2:0]           LOW3_EXT      = 3'd7;
    localparam logic [LIT_CNT_W-1:0] LIT_EXT_BASE  = 9'd8;
    localparam logic [HDR_IDX_W-1:0] HDR_CNT_B0    = 3'd3;
    localparam logic [HDR_IDX_W-1:0] HDR_CNT_B1    = 3'd4;
    localparam logic [HDR_IDX_W-1:0] HDR_CNT_B2    = 3'd5;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN       = HDR_IDX_W'(HEADER_BYTES);

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } t_in_word;

    typedef struct packed {
        logic             vld;
        logic [SEL_W-1:0] sel;
        logic [7:0]       data;
        logic             last;
    } t_result;

    typedef struct packed {
        logic                 is_lit;
        logic [LIT_CNT_W-1:0] remaining;
        logic [PHASE_W-1:0]   phase;
    } t_blk;

    // Decodes one size nibble into the first parse phase of its block.
    function automatic t_blk begin_block(input logic [3:0] nib);
        t_blk blk;
        blk.is_lit = nib[3];
        if (nib[2:0] == LOW3_EXT) begin
            blk.remaining = LIT_EXT_BASE;
            blk.phase     = PH_EXTRA;
        end else if (nib[3]) begin
            blk.remaining = LIT_CNT_W'(nib[2:0]) + LIT_CNT_W'(1);
            blk.phase     = PH_LITS;
        end else begin
            blk.remaining = '0;
            blk.phase     = PH_OFFLO;
        end
        return blk;
    endfunction

endpackage

// File: src/lzs_in_stage.sv
// Input register of the splitter: holds one word and frees itself as the parser consumes it.
`timescale 1ns / 1ps
module lzs_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_in_byte,
    input  logic              i_frame_start,
    input  logic              i_out_ready,
    output logic              o_adv,
    output lzs_pkg::t_in_word o_word
);
    import lzs_pkg::*;

    logic     r_valid;
    t_in_word r_word;
    logic     w_adv;
    logic     w_load;

    // The held word is consumed whenever the result register can take its outcome.
    assign w_adv      = r_valid && i_out_ready;
    assign w_load     = !r_valid || w_adv;
    assign o_in_stall = !w_load;
    assign o_adv      = w_adv;
    assign o_word     = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_in_valid) begin
            r_word.start <= i_frame_start;
            r_word.data  <= i_in_byte;
        end
    end

endmodule

// File: src/lzs_parser.sv
// Parse state and its combinational update: routes at most one byte per consumed word.
`timescale 1ns / 1ps
module lzs_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  lzs_pkg::t_in_word i_word,
    output lzs_pkg::t_result  o_res
);
    import lzs_pkg::*;

    logic [PHASE_W-1:0]   r_phase,     n_phase;
    logic [HDR_IDX_W-1:0] r_hdr_idx,   n_hdr_idx;
    logic [BLK_CNT_W-1:0] r_blk_total, n_blk_total;
    logic [BLK_CNT_W-1:0] r_blk_done,  n_blk_done;
    logic [3:0]           r_saved_nib, n_saved_nib;
    logic                 r_second,    n_second;
    logic                 r_is_lit,    n_is_lit;
    logic [LIT_CNT_W-1:0] r_lit_rem,   n_lit_rem;

    logic [PHASE_W-1:0]   e_phase;
    logic [HDR_IDX_W-1:0] e_hdr_idx;
    logic [BLK_CNT_W-1:0] e_blk_total;
    logic [BLK_CNT_W-1:0] e_blk_done;
    logic [3:0]           e_saved_nib;
    logic                 e_second;
    logic                 e_is_lit;
    logic [LIT_CNT_W-1:0] e_lit_rem;

    logic [HDR_IDX_W-1:0] w_idx_inc;
    logic [BLK_CNT_W-1:0] w_done_inc;
    logic                 w_end;
    t_blk                 w_blk;
    t_blk                 w_blk_next;

    // A frame start acts as a reset applied just before the byte is parsed.
    always_comb begin
        if (i_word.start) begin
            e_phase     = PH_HEADER;
            e_hdr_idx   = '0;
            e_blk_total = '0;
            e_blk_done  = '0;
            e_saved_nib = '0;
            e_second    = 1'b0;
            e_is_lit    = 1'b0;
            e_lit_rem   = '0;
        end else begin
            e_phase     = r_phase;
            e_hdr_idx   = r_hdr_idx;
            e_blk_total = r_blk_total;
            e_blk_done  = r_blk_done;
            e_saved_nib = r_saved_nib;
            e_second    = r_second;
            e_is_lit    = r_is_lit;
            e_lit_rem   = r_lit_rem;
        end
    end

    assign w_idx_inc  = e_hdr_idx + HDR_IDX_W'(1);
    assign w_done_inc = e_blk_done + BLK_CNT_W'(1);
    assign w_blk      = begin_block(i_word.data[7:4]);
    assign w_blk_next = begin_block(e_saved_nib);

    always_comb begin
        n_phase     = e_phase;
        n_hdr_idx   = e_hdr_idx;
        n_blk_total = e_blk_total;
        n_blk_done  = e_blk_done;
        n_saved_nib = e_saved_nib;
        n_second    = e_second;
        n_is_lit    = e_is_lit;
        n_lit_rem   = e_lit_rem;
        o_res.vld   = 1'b0;
        o_res.sel   = SEL_SIZE;
        o_res.data  = i_word.data;
        o_res.last  = 1'b0;
        w_end       = 1'b0;

        case (e_phase)
            PH_HEADER: begin
                if (e_hdr_idx == HDR_CNT_B0) begin
                    n_blk_total = BLK_CNT_W'(i_word.data);
                end else if (e_hdr_idx == HDR_CNT_B1) begin
                    n_blk_total = {e_blk_total[23:16], i_word.data, e_blk_total[7:0]};
                end else if (e_hdr_idx == HDR_CNT_B2) begin
                    n_blk_total = {i_word.data, e_blk_total[15:0]};
                end
                n_hdr_idx = w_idx_inc;
                if (w_idx_inc >= HDR_LEN) begin
                    n_hdr_idx  = '0;
                    n_blk_done = '0;
                    n_phase    = (n_blk_total == '0) ? PH_DONE : PH_SIZE;
                end
            end
            PH_SIZE: begin
                o_res.vld   = 1'b1;
                o_res.sel   = SEL_SIZE;
                n_saved_nib = i_word.data[3:0];
                n_second    = 1'b0;
                n_is_lit    = w_blk.is_lit;
                n_lit_rem   = w_blk.remaining;
                n_phase     = w_blk.phase;
            end
            PH_EXTRA: begin
                o_res.vld = 1'b1;
                if (e_is_lit) begin
                    o_res.sel = SEL_XLIT;
                    n_lit_rem = LIT_EXT_BASE + LIT_CNT_W'(i_word.data);
                    n_phase   = PH_LITS;
                end else begin
                    o_res.sel = SEL_XREP;
                    n_phase   = PH_OFFLO;
                end
            end
            PH_LITS: begin
                o_res.vld = 1'b1;
                o_res.sel = SEL_LIT;
                if (e_lit_rem != '0) begin
                    n_lit_rem = e_lit_rem - LIT_CNT_W'(1);
                end
                w_end = (n_lit_rem == '0);
            end
            PH_OFFLO: begin
                o_res.vld = 1'b1;
                o_res.sel = SEL_OFFLO;
                n_phase   = PH_OFFHI;
            end
            PH_OFFHI: begin
                o_res.vld = 1'b1;
                o_res.sel = SEL_OFFHI;
                w_end     = 1'b1;
            end
            default: begin
                o_res.vld = 1'b0;
            end
        endcase

        // Closing a block either finishes the frame, starts the saved low nibble,
        // or goes back for the next size byte.
        if (w_end) begin
            n_blk_done = w_done_inc;
            if (w_done_inc == e_blk_total) begin
                n_phase    = PH_DONE;
                o_res.last = 1'b1;
            end else if (!e_second) begin
                n_second  = 1'b1;
                n_is_lit  = w_blk_next.is_lit;
                n_lit_rem = w_blk_next.remaining;
                n_phase   = w_blk_next.phase;
            end else begin
                n_phase = PH_SIZE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_idx   <= '0;
            r_blk_total <= '0;
            r_blk_done  <= '0;
            r_saved_nib <= '0;
            r_second    <= 1'b0;
            r_is_lit    <= 1'b0;
            r_lit_rem   <= '0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_hdr_idx   <= n_hdr_idx;
            r_blk_total <= n_blk_total;
            r_blk_done  <= n_blk_done;
            r_saved_nib <= n_saved_nib;
            r_second    <= n_second;
            r_is_lit    <= n_is_lit;
            r_lit_rem   <= n_lit_rem;
        end
    end

endmodule

// File: src/lzs_out_stage.sv
// Result register of the splitter: holds one routed word until downstream takes it.
`timescale 1ns / 1ps
module lzs_out_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  lzs_pkg::t_result            i_res,
    output logic                        o_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [lzs_pkg::SEL_W-1:0]   o_stream_sel,
    output logic [7:0]                  o_out_byte,
    output logic                        o_frame_last
);
    import lzs_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    w_ready;

    assign w_ready      = !r_valid || !i_out_stall;
    assign o_ready      = w_ready;
    assign o_out_valid  = r_valid;
    assign o_stream_sel = r_res.sel;
    assign o_out_byte   = r_res.data;
    assign o_frame_last = r_res.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_adv && i_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_adv && i_res.vld) begin
            r_res <= i_res;
        end
    end

endmodule

// File: src/lz_token_stream_splitter_top.sv
// Top level of the token stream splitter: input register, parser and result register.
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_in_byte, i_frame_start
//  out       output     o_out_valid / i_out_stall o_stream_sel, o_out_byte, o_frame_last
//
// A word passes through the input register, from which the parser updates its state,
// and then the result register, which holds the outcome.
// One word is accepted per cycle while the output does not stall; header and trailing words produce no result.
// Reset is synchronous on i_rst_n and puts the parser back into the header phase.
// A stall on the output holds the result register and, through it, the input side.
`timescale 1ns / 1ps
module lz_token_stream_splitter_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [7:0]                i_in_byte,
    input  logic                      i_frame_start,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [lzs_pkg::SEL_W-1:0] o_stream_sel,
    output logic [7:0]                o_out_byte,
    output logic                      o_frame_last
);
    import lzs_pkg::*;

    logic     w_out_ready;
    logic     w_adv;
    t_in_word w_word;
    t_result  w_res;

    lzs_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_frame_start (i_frame_start),
        .i_out_ready   (w_out_ready),
        .o_adv         (w_adv),
        .o_word        (w_word)
    );

    lzs_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_word  (w_word),
        .o_res   (w_res)
    );

    lzs_out_stage u_out_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_res        (w_res),
        .o_ready      (w_out_ready),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_stream_sel (o_stream_sel),
        .o_out_byte   (o_out_byte),
        .o_frame_last (o_frame_last)
    );

endmodule

// File: test/lz_token_stream_splitter_top_tb.sv
// Self-checking testbench for the token stream splitter: framed byte stimulus against a predictor.
`timescale 1ns / 1ps
module lz_token_stream_splitter_top_tb;
    import lzs_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int WORDS_PER_PHASE = 300;

    typedef struct packed {
        logic [SEL_W-1:0] sel;
        logic [7:0]       data;
        logic             last;
    } t_routed_word;

    // Tracks the parse state of the token stream and holds the routed words still due.
    class splitter_scoreboard;
        logic [PHASE_W-1:0]   phase;
        logic [HDR_IDX_W-1:0] hdr_idx;
        logic [BLK_CNT_W-1:0] blk_total;
        logic [BLK_CNT_W-1:0] blk_done;
        logic [3:0]           low_nib;
        logic                 second_nib;
        logic                 is_lit;
        logic [LIT_CNT_W-1:0] lit_left;
        t_routed_word         due_q[$];
        int                   errors;
        int                   checked;
        int                   closed;

        function new();
            clear_parse();
            errors  = 0;
            checked = 0;
            closed  = 0;
        endfunction

        function void clear_parse();
            phase      = PH_HEADER;
            hdr_idx    = '0;
            blk_total  = '0;
            blk_done   = '0;
            low_nib    = '0;
            second_nib = 1'b0;
            is_lit     = 1'b0;
            lit_left   = '0;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void start_block(logic [3:0] nib);
            is_lit = nib[3];
            if (nib[2:0] == LOW3_EXT) begin
                lit_left = LIT_EXT_BASE;
                phase    = PH_EXTRA;
            end else if (nib[3]) begin
                lit_left = LIT_CNT_W'(nib[2:0]) + LIT_CNT_W'(1);
                phase    = PH_LITS;
            end else begin
                lit_left = '0;
                phase    = PH_OFFLO;
            end
        endfunction

        // Closes the current block and returns 1 when it was the last one of the frame.
        function logic close_block();
            blk_done = blk_done + 1'b1;
            if (blk_done == blk_total) begin
                phase = PH_DONE;
                return 1'b1;
            end
            if (!second_nib) begin
                second_nib = 1'b1;
                start_block(low_nib);
            end else begin
                phase = PH_SIZE;
            end
            return 1'b0;
        endfunction

        function void note_word(logic [7:0] b, logic start);
            t_routed_word w;
            logic         routed;
            if (start) clear_parse();
            routed = 1'b1;
            w.sel  = SEL_SIZE;
            w.data = b;
            w.last = 1'b0;
            case (phase)
                PH_HEADER: begin
                    if (hdr_idx == HDR_CNT_B0) blk_total = BLK_CNT_W'(b);
                    else if (hdr_idx == HDR_CNT_B1) blk_total[15:8] = blk_total[15:8] | b;
                    else if (hdr_idx == HDR_CNT_B2) blk_total[23:16] = blk_total[23:16] | b;
                    hdr_idx = hdr_idx + 1'b1;
                    if (hdr_idx >= HDR_LEN) begin
                        hdr_idx  = '0;
                        blk_done = '0;
                        phase    = (blk_total == 0) ? PH_DONE : PH_SIZE;
                    end
                    routed = 1'b0;
                end
                PH_SIZE: begin
                    w.sel      = SEL_SIZE;
                    low_nib    = b[3:0];
                    second_nib = 1'b0;
                    start_block(b[7:4]);
                end
                PH_EXTRA: begin
                    if (is_lit) begin
                        w.sel    = SEL_XLIT;
                        lit_left = LIT_EXT_BASE + LIT_CNT_W'(b);
                        phase    = PH_LITS;
                    end else begin
                        w.sel = SEL_XREP;
                        phase = PH_OFFLO;
                    end
                end
                PH_LITS: begin
                    w.sel = SEL_LIT;
                    if (lit_left != 0) lit_left = lit_left - 1'b1;
                    if (lit_left == 0) w.last = close_block();
                end
                PH_OFFLO: begin
                    w.sel = SEL_OFFLO;
                    phase = PH_OFFHI;
                end
                PH_OFFHI: begin
                    w.sel  = SEL_OFFHI;
                    w.last = close_block();
                end
                default: routed = 1'b0;
            endcase
            if (routed) due_q.insert(due_q.size(), w);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic [SEL_W-1:0] sel, logic [7:0] data, logic last);
            t_routed_word w;
            if (due_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual sel %0d byte %0d last %0d",
                         $time, sel, data, last);
                errors++;
                return;
            end
            w = due_q.pop_front();
            checked++;
            if (last === 1'b1) closed++;
            compare_field("stream_sel", w.sel, sel);
            compare_field("out_byte", w.data, data);
            compare_field("frame_last", w.last, last);
            if ($isunknown({sel, data, last})) begin
                $display("%0t: unknown bits, expected %0d/%0d/%0d, actual %b/%b/%b",
                         $time, w.sel, w.data, w.last, sel, data, last);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_in_valid    = 1'b0;
    logic             o_in_stall;
    logic [7:0]       i_in_byte     = 8'h00;
    logic             i_frame_start = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall   = 1'b0;
    logic [SEL_W-1:0] o_stream_sel;
    logic [7:0]       o_out_byte;
    logic             o_frame_last;

    splitter_scoreboard sb = new();

    int          idle_pct     = 0;
    int          stall_pct    = 0;
    int          words_sent   = 0;
    int          aborts       = 0;
    int          quiet_cycles = 0;
    logic [7:0]  frame_q[$];

    lz_token_stream_splitter_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_frame_start(i_frame_start),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_stream_sel (o_stream_sel),
        .o_out_byte   (o_out_byte),
        .o_frame_last (o_frame_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            sb.check_word(o_stream_sel, o_out_byte, o_frame_last);
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0)
                || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // Appends one byte to the frame being built.
    task automatic add_byte(input logic [7:0] x);
        frame_q.insert(frame_q.size(), x);
    endtask

    // Offers one word, with random idle cycles in front, and returns at its acceptance edge.
    task automatic send_word(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_byte     <= b;
        i_frame_start <= start;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_word(b, start);
        words_sent++;
    endtask

    task automatic send_frame_q(input logic start, input int n);
        for (int k = 0; k < n; k++) send_word(frame_q[k], start && k == 0);
    endtask

    task automatic add_block_body(input logic [3:0] nib);
        int         n;
        logic [7:0] x;
        n = 0;
        if (nib[2:0] == LOW3_EXT) begin
            x = ($urandom_range(99) < 5) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
            add_byte(x);
            if (nib[3]) n = int'(LIT_EXT_BASE) + x;
        end else if (nib[3]) begin
            n = nib[2:0] + 1;
        end
        if (!nib[3]) n = 2;
        repeat (n) add_byte(8'($urandom_range(255)));
    endtask

    // Well-formed frames with random content; a few carry huge counts, and those and some others get cut short.
    task automatic send_random_frame();
        int         pick;
        int         count;
        int         gen_blocks;
        int         n;
        logic [3:0] nib_hi;
        logic [3:0] nib_lo;
        frame_q.delete();
        pick = $urandom_range(99);
        if (pick < 5) count = 0;
        else if (pick < 10) count = $urandom_range(24'hFFFFFF, 9);
        else count = $urandom_range(7, 1);
        gen_blocks = (count > 8) ? $urandom_range(8, 1) : count;
        repeat (3) add_byte(8'($urandom_range(255)));
        add_byte(count[7:0]);
        add_byte(count[15:8]);
        add_byte(count[23:16]);
        for (int b = 0; b < gen_blocks; b += 2) begin
            nib_hi = 4'($urandom_range(15));
            nib_lo = 4'($urandom_range(15));
            add_byte({nib_hi, nib_lo});
            add_block_body(nib_hi);
            if (b + 1 < gen_blocks) add_block_body(nib_lo);
        end
        n = frame_q.size();
        if ($urandom_range(99) < 10 || count > 8) begin
            n = $urandom_range(frame_q.size(), 1);
            aborts++;
        end
        send_frame_q($urandom_range(99) < 97, n);
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(3, 1)) send_word(8'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First frame after reset comes without a frame start mark.
        frame_q = '{8'hAA, 8'h55, 8'hFF, 8'h03, 8'h00, 8'h00,
                    8'h87, 8'hFF, 8'h00, 8'h12, 8'h80,
                    8'h7F, 8'hFF, 8'h01, 8'hFE};
        send_frame_q(1'b0, frame_q.size());
        send_word(8'h5A, 1'b0);
        // A zero block count routes nothing, and the bytes after it are dropped.
        frame_q = '{8'h01, 8'h02, 8'h03, 8'h00, 8'h00, 8'h00};
        send_frame_q(1'b1, frame_q.size());
        send_word(8'hC3, 1'b0);
        // Largest block count, aborted by the next frame start.
        frame_q = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hA0, 8'h00, 8'hFF, 8'h80};
        send_frame_q(1'b1, frame_q.size());
        aborts++;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            while (words_sent < (ph + 1) * WORDS_PER_PHASE + 40) send_random_frame();
            drain_results();
        end

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d stream bytes in %0d idle/stall settings; %0d routed words checked.",
                 words_sent, 4, sb.checked);
        $display("Frames closed on their last block: %0d; frames cut by a new start: %0d.",
                 sb.closed, aborts);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
